// ===== rtl/skl_pkg.sv =====
// shared types, constants and face derivation for the style keyed lru cache
// no dependencies; used by skl_ctrl, skl_dp and style_keyed_lru_cache_top
package skl_pkg;

   // cache geometry
   localparam int CACHE_ENTRIES = 32;
   localparam int IDX_W = $clog2(CACHE_ENTRIES);
   localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

   // field widths
   localparam int FAMILY_W = 3;
   localparam int WEIGHT_W = 10;
   localparam int SIZE_W = 24;
   localparam int FACE_W = 5;
   localparam int TF_W = 8;
   localparam int SLOT_W = 5;
   localparam int STAMP_W = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 8;

   // weight class thresholds
   localparam logic [WEIGHT_W-1:0] WEIGHT_HEAVY = WEIGHT_W'(800);
   localparam logic [WEIGHT_W-1:0] WEIGHT_BOLD = WEIGHT_W'(600);
   localparam logic [WEIGHT_W-1:0] WEIGHT_LIGHT = WEIGHT_W'(300);

   // face code bits
   localparam logic [FACE_W-1:0] FACE_ITALIC = 5'h01;
   localparam logic [FACE_W-1:0] FACE_BOLD = 5'h02;
   localparam logic [FACE_W-1:0] FACE_HEAVY = 5'h04;
   localparam logic [FACE_W-1:0] FACE_LIGHT = 5'h08;
   localparam logic [FACE_W-1:0] FACE_REGULAR = 5'h10;

   // generic family codes
   localparam logic [FAMILY_W-1:0] FAM_SERIF = 3'd1;
   localparam logic [FAMILY_W-1:0] FAM_MONO = 3'd2;
   localparam logic [FAMILY_W-1:0] FAM_CURSIVE = 3'd3;
   localparam logic [FAMILY_W-1:0] FAM_FANTASY = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SANS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SERIF = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MONO = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CURSIVE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FANTASY = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic scan;
      logic update;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic rsp_free;
   } status_type;

   typedef struct packed {
      logic [TF_W-1:0]   typeface;
      logic [FACE_W-1:0] face;
      logic [SIZE_W-1:0] size;
   } key_type;

   typedef struct packed {
      key_type            key;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   function automatic logic [FACE_W-1:0] derive_face(
      input logic italic,
      input logic oblique,
      input logic [WEIGHT_W-1:0] weight
   );
      logic [FACE_W-1:0] face;
      face = '0;
      if (italic || oblique) begin
         face = FACE_ITALIC;
      end
      if (weight >= WEIGHT_HEAVY) begin
         face = face | FACE_HEAVY;
      end else if (weight >= WEIGHT_BOLD) begin
         face = face | FACE_BOLD;
      end else if (weight <= WEIGHT_LIGHT) begin
         face = face | FACE_LIGHT;
      end
      if (face == '0) begin
         face = FACE_REGULAR;
      end
      return face;
   endfunction

endpackage

// ===== rtl/skl_ctrl.sv =====
// controller state machine for the style keyed lru cache
// depends on skl_pkg; drives commands into skl_dp and the request stall
module skl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  skl_pkg::status_type status,
   output skl_pkg::cmd_type    cmd
);

   skl_pkg::state_type state_ff;
   skl_pkg::state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         skl_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = skl_pkg::ST_SEARCH;
            end
         end
         skl_pkg::ST_SEARCH: begin
            if (status.scan_done) begin
               state_in = skl_pkg::ST_UPDATE;
            end
         end
         skl_pkg::ST_UPDATE: begin
            if (status.rsp_free) begin
               state_in = skl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skl_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         skl_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         skl_pkg::ST_SEARCH: begin
            cmd.scan = 1'b1;
         end
         skl_pkg::ST_UPDATE: begin
            cmd.update = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/skl_dp.sv =====
// datapath for the style keyed lru cache: config registers, key capture,
// entry memory, tag search with oldest stamp tracking, result register
// depends on skl_pkg; commanded by skl_ctrl
module skl_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  skl_pkg::cmd_type                    cmd,
   output skl_pkg::status_type                 status,
   input  logic [skl_pkg::FAMILY_W-1:0]        req_family_code,
   input  logic                                req_italic_flag,
   input  logic                                req_oblique_flag,
   input  logic [skl_pkg::WEIGHT_W-1:0]        req_weight,
   input  logic [skl_pkg::SIZE_W-1:0]          req_scaled_size,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic [skl_pkg::SLOT_W-1:0]          rsp_slot,
   output logic [skl_pkg::FACE_W-1:0]          rsp_face_code,
   output logic [skl_pkg::TF_W-1:0]            rsp_typeface_id,
   output logic                                rsp_evicted,
   input  logic                                csr_write_en,
   input  logic [skl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [skl_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   // configuration registers
   logic [skl_pkg::TF_W-1:0] sans_ff, serif_ff, mono_ff, cursive_ff, fantasy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sans_ff <= skl_pkg::TF_W'(1);
         serif_ff <= skl_pkg::TF_W'(2);
         mono_ff <= skl_pkg::TF_W'(3);
         cursive_ff <= skl_pkg::TF_W'(4);
         fantasy_ff <= skl_pkg::TF_W'(5);
      end else if (csr_write_en) begin
         case (csr_index)
            skl_pkg::REG_SANS:    sans_ff <= csr_write_data;
            skl_pkg::REG_SERIF:   serif_ff <= csr_write_data;
            skl_pkg::REG_MONO:    mono_ff <= csr_write_data;
            skl_pkg::REG_CURSIVE: cursive_ff <= csr_write_data;
            skl_pkg::REG_FANTASY: fantasy_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // typeface pick per family
   logic [skl_pkg::TF_W-1:0] tf_pick;

   always_comb begin
      case (req_family_code)
         skl_pkg::FAM_SERIF:   tf_pick = serif_ff;
         skl_pkg::FAM_MONO:    tf_pick = mono_ff;
         skl_pkg::FAM_CURSIVE: tf_pick = cursive_ff;
         skl_pkg::FAM_FANTASY: tf_pick = fantasy_ff;
         default:              tf_pick = sans_ff;
      endcase
   end

   // key capture and usage clock
   skl_pkg::key_type key_ff;
   logic [skl_pkg::STAMP_W-1:0] clock_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff.typeface <= tf_pick;
         key_ff.face <= skl_pkg::derive_face(req_italic_flag, req_oblique_flag, req_weight);
         key_ff.size <= req_scaled_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff <= '0;
      end else if (cmd.start) begin
         clock_ff <= clock_ff + skl_pkg::STAMP_W'(1);
      end
   end

   // entry memory
   skl_pkg::entry_type mem [skl_pkg::CACHE_ENTRIES];
   skl_pkg::entry_type rd_data_ff;
   logic [skl_pkg::CNT_W-1:0] filled_ff;
   logic [skl_pkg::CNT_W-1:0] rd_idx_ff;
   logic [skl_pkg::IDX_W-1:0] cmp_idx_ff;
   logic cmp_vld_ff;
   logic found_ff;
   logic [skl_pkg::IDX_W-1:0] found_idx_ff;
   logic min_vld_ff;
   logic [skl_pkg::STAMP_W-1:0] min_stamp_ff;
   logic [skl_pkg::IDX_W-1:0] min_idx_ff;
   logic issue;
   logic match;
   logic full;
   logic [skl_pkg::IDX_W-1:0] target;
   logic wr_en;

   assign issue = cmd.scan && !found_ff && (rd_idx_ff < filled_ff);
   assign match = cmp_vld_ff && (rd_data_ff.key == key_ff);
   assign full = (filled_ff == skl_pkg::CNT_W'(skl_pkg::CACHE_ENTRIES));

   // one entry read per cycle during the search
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem[rd_idx_ff[skl_pkg::IDX_W-1:0]];
         cmp_idx_ff <= rd_idx_ff[skl_pkg::IDX_W-1:0];
      end
   end

   // search control: address counter, hit and oldest stamp tracking
   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         rd_idx_ff <= '0;
         cmp_vld_ff <= 1'b0;
         found_ff <= 1'b0;
         min_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= issue;
         if (issue) begin
            rd_idx_ff <= rd_idx_ff + skl_pkg::CNT_W'(1);
         end
         if (match && !found_ff) begin
            found_ff <= 1'b1;
         end
         if (cmp_vld_ff && (!min_vld_ff || rd_data_ff.stamp < min_stamp_ff)) begin
            min_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (match && !found_ff) begin
         found_idx_ff <= cmp_idx_ff;
      end
      if (cmp_vld_ff && (!min_vld_ff || rd_data_ff.stamp < min_stamp_ff)) begin
         min_stamp_ff <= rd_data_ff.stamp;
         min_idx_ff <= cmp_idx_ff;
      end
   end

   assign status.scan_done = cmd.scan && (found_ff || (!cmp_vld_ff && !issue));

   // replacement choice: hit entry, next empty entry, or oldest entry
   always_comb begin
      if (found_ff) begin
         target = found_idx_ff;
      end else if (!full) begin
         target = filled_ff[skl_pkg::IDX_W-1:0];
      end else begin
         target = min_idx_ff;
      end
   end

   assign wr_en = cmd.update;

   // entry write: key and fresh stamp
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[target] <= '{key: key_ff, stamp: clock_ff};
      end
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
      end else if (wr_en && !found_ff && !full) begin
         filled_ff <= filled_ff + skl_pkg::CNT_W'(1);
      end
   end

   // result register
   logic rsp_valid_ff;

   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (wr_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rsp_hit <= found_ff;
         rsp_slot <= skl_pkg::SLOT_W'(target);
         rsp_face_code <= key_ff.face;
         rsp_typeface_id <= key_ff.typeface;
         rsp_evicted <= !found_ff && full;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/style_keyed_lru_cache_top.sv =====
// top level of the style keyed lru cache
// depends on skl_pkg, skl_ctrl and skl_dp
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   family, italic, oblique, weight, size
//   rsp       out        rsp_valid/rsp_stall   hit, slot, face code, typeface id, evicted
//   csr       in         csr_write_en          csr_index, csr_write_data
//
// a miss passes through the accept in ST_IDLE, a tag search in ST_SEARCH that reads one
// entry per cycle from the single memory read port while tracking the oldest stamp and
// then drains the compare, and the write back in ST_UPDATE. a hit ends the search early.
// a stalled result holds the write back.
// reset loads the default typeface ids and clears the fill count and the usage clock.
// one transaction is in flight at a time; the result register lets a new
// request enter while the previous result is still stalled.
module style_keyed_lru_cache_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [skl_pkg::FAMILY_W-1:0]   req_family_code,
   input  logic                           req_italic_flag,
   input  logic                           req_oblique_flag,
   input  logic [skl_pkg::WEIGHT_W-1:0]   req_weight,
   input  logic [skl_pkg::SIZE_W-1:0]     req_scaled_size,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_hit,
   output logic [skl_pkg::SLOT_W-1:0]     rsp_slot,
   output logic [skl_pkg::FACE_W-1:0]     rsp_face_code,
   output logic [skl_pkg::TF_W-1:0]       rsp_typeface_id,
   output logic                           rsp_evicted,
   input  logic                           csr_write_en,
   input  logic [skl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [skl_pkg::CSR_DATA_W-1:0] csr_write_data
);

   skl_pkg::cmd_type    cmd;
   skl_pkg::status_type status;

   // controller
   skl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   skl_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_family_code  (req_family_code),
      .req_italic_flag  (req_italic_flag),
      .req_oblique_flag (req_oblique_flag),
      .req_weight       (req_weight),
      .req_scaled_size  (req_scaled_size),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_slot         (rsp_slot),
      .rsp_face_code    (rsp_face_code),
      .rsp_typeface_id  (rsp_typeface_id),
      .rsp_evicted      (rsp_evicted),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

endmodule
